// ----- sv/qrbv_pkg.sv -----
// Shared types and codes for the queue with remove by value.
// No dependencies; imported by qrbv_mem, queue_with_remove_by_value_top and the testbench.
package qrbv_pkg;

    // Result field widths fixed by the interface
    localparam int OCC_W  = 7;
    localparam int DATA_W = 32;

    // Requested operation, carried in s_tuser
    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_PEEK    = 2'd2,
        ACT_REMOVE  = 2'd3
    } action_t;

    // Result status, carried in m_tuser
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_EMPTY     = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_SHIFT
    } state_t;

endpackage

// ----- sv/qrbv_mem.sv -----
// Entry store: one write port, one read port with registered read data.
// Depends on qrbv_pkg for the data width.
module qrbv_mem
    import qrbv_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/queue_with_remove_by_value_top.sv -----
// Queue with remove by value: circular store, one compare unit, small sequencer.
// Enqueue and empty-queue results load on acceptance; dequeue/peek pass through S_READ;
// for remove, the single read port walks one entry per cycle for search and gap closing.
// Throughput: one beat at a time; the next input beat is taken once the result has left.
// Reset: aresetn clears pointers, fill count, sequencer and output valid; store contents
// are not cleared (only slots below the fill count are ever read).
module queue_with_remove_by_value_top
    import qrbv_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] action
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] data, [38:32] occupancy, [39] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // circular address: (base + off) mod DEPTH, off <= DEPTH
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    state_t            state_reg, state_next;
    action_t           act_reg, act_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;

    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg, m_status_next;
    logic [DATA_W-1:0] m_data_reg, m_data_next;
    logic [OCC_W-1:0]  m_occ_reg, m_occ_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic              s_accept;
    logic              out_load;
    logic              hit;
    logic [OCC_W+CW-1:0] occ_ext;

    qrbv_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    // the shared compare unit
    assign hit = (rd_data == val_reg);

    // occupancy reported modulo 2^7
    assign occ_ext = {{OCC_W{1'b0}}, count_next};

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        val_reg      <= val_next;
        idx_reg      <= idx_next;
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
        m_occ_reg    <= m_occ_next;
    end

    // sequencer: next state, store ports and result
    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        val_next      = val_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        wr_en         = 1'b0;
        wr_addr       = wrap_add(head_reg, count_reg);
        wr_data       = val_reg;
        rd_addr       = head_reg;
        out_load      = 1'b0;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    act_next = action_t'(s_tuser);
                    val_next = s_tdata;
                    idx_next = '0;
                    priority if (action_t'(s_tuser) == ACT_ENQUEUE) begin
                        out_load    = 1'b1;
                        m_data_next = '0;
                        if (count_reg == CW'(DEPTH)) begin
                            m_status_next = STS_FULL;
                        end else begin
                            wr_en         = 1'b1;
                            wr_data       = s_tdata;
                            count_next    = count_reg + 1'b1;
                            m_status_next = STS_OK;
                        end
                    end else if (count_reg == '0) begin
                        out_load      = 1'b1;
                        m_status_next = STS_EMPTY;
                        m_data_next   = '0;
                    end else if (action_t'(s_tuser) == ACT_REMOVE) begin
                        state_next = S_SEARCH;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            // front entry is in rd_data
            S_READ: begin
                out_load      = 1'b1;
                m_status_next = STS_OK;
                m_data_next   = rd_data;
                if (act_reg == ACT_DEQUEUE) begin
                    head_next  = wrap_add(head_reg, CW'(1));
                    count_next = count_reg - 1'b1;
                end
                state_next = S_IDLE;
            end
            // rd_data holds entry idx_reg; read the next one meanwhile
            S_SEARCH: begin
                if (hit) begin
                    if (idx_reg + 1'b1 == count_reg) begin
                        count_next    = count_reg - 1'b1;
                        out_load      = 1'b1;
                        m_status_next = STS_OK;
                        m_data_next   = '0;
                        state_next    = S_IDLE;
                    end else begin
                        rd_addr    = wrap_add(head_reg, idx_reg + 1'b1);
                        state_next = S_SHIFT;
                    end
                end else if (idx_reg + 1'b1 == count_reg) begin
                    out_load      = 1'b1;
                    m_status_next = STS_NOT_FOUND;
                    m_data_next   = '0;
                    state_next    = S_IDLE;
                end else begin
                    rd_addr  = wrap_add(head_reg, idx_reg + 1'b1);
                    idx_next = idx_reg + 1'b1;
                end
            end
            // rd_data holds entry idx_reg+1; move it into slot idx_reg
            S_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = wrap_add(head_reg, idx_reg);
                wr_data = rd_data;
                if (idx_reg + 2'd2 == count_reg) begin
                    count_next    = count_reg - 1'b1;
                    out_load      = 1'b1;
                    m_status_next = STS_OK;
                    m_data_next   = '0;
                    state_next    = S_IDLE;
                end else begin
                    rd_addr  = wrap_add(head_reg, idx_reg + 2'd2);
                    idx_next = idx_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_occ_next = m_occ_reg;
        if (out_load) begin
            m_occ_next   = occ_ext[OCC_W-1:0];
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {1'b0, m_occ_reg, m_data_reg};

`ifndef SYNTHESIS
    // fill count never passes the store depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    // search walks only over held entries
    a_search_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEARCH) |-> (idx_reg < count_reg))
        else $error("search index past fill count");

    // gap closing always has a later entry to move
    a_shift_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT) |-> (idx_reg + 1'b1 < count_reg))
        else $error("shift index past fill count");

    // an accepted enqueue with room grows the queue by one
    a_enq_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && action_t'(s_tuser) == ACT_ENQUEUE && count_reg != CW'(DEPTH))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("enqueue did not grow fill count");
`endif

endmodule

// ----- tb/queue_with_remove_by_value_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for queue_with_remove_by_value_top: directed table, then random mixes.
// Depends on qrbv_pkg and the top module; keeps its own copy of the queue to predict each result.
module queue_with_remove_by_value_top_tb;
    import qrbv_pkg::*;

    localparam int DEPTH     = 64;
    localparam int N_DIR     = 22;
    localparam int N_RANDOM  = 1330;
    localparam int MAX_IDLE  = 17;

    // one result beat as seen on the result channel
    typedef struct packed {
        status_t                  status;
        logic [DATA_W-1:0]        data;
        logic [OCC_W-1:0]         occupancy;
    } q_result_t;

    // directed table row; known rows carry a typed-in result
    typedef struct packed {
        action_t                  act;
        logic [31:0]              value;
        logic                     known;
        q_result_t                want;
    } dir_row_t;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    logic [31:0] held_q[$];          // predicted queue contents, front first
    q_result_t   pending_results[$]; // results owed by the block, oldest first
    int          fail_cnt = 0;
    bit          idle_on  = 1'b1;    // both sides idle at random while set

    // Walk through empty-queue cases, extremes, duplicates and front/middle/back removes
    dir_row_t dir_rows [N_DIR] = '{
        '{ACT_DEQUEUE, 32'h0000_0000, 1'b1, '{STS_EMPTY,     32'h0000_0000, 7'd0}},
        '{ACT_PEEK,    32'hFFFF_FFFF, 1'b1, '{STS_EMPTY,     32'h0000_0000, 7'd0}},
        '{ACT_REMOVE,  32'h0000_0005, 1'b1, '{STS_EMPTY,     32'h0000_0000, 7'd0}},
        '{ACT_ENQUEUE, 32'h7FFF_FFFF, 1'b1, '{STS_OK,        32'h0000_0000, 7'd1}},
        '{ACT_ENQUEUE, 32'h8000_0000, 1'b1, '{STS_OK,        32'h0000_0000, 7'd2}},
        '{ACT_ENQUEUE, 32'h0000_0000, 1'b1, '{STS_OK,        32'h0000_0000, 7'd3}},
        '{ACT_ENQUEUE, 32'hFFFF_FFFF, 1'b1, '{STS_OK,        32'h0000_0000, 7'd4}},
        '{ACT_ENQUEUE, 32'h8000_0000, 1'b1, '{STS_OK,        32'h0000_0000, 7'd5}},
        '{ACT_PEEK,    32'h0000_0000, 1'b1, '{STS_OK,        32'h7FFF_FFFF, 7'd5}},
        '{ACT_REMOVE,  32'h1234_5678, 1'b1, '{STS_NOT_FOUND, 32'h0000_0000, 7'd5}},
        // duplicate: only the copy nearest the front goes
        '{ACT_REMOVE,  32'h8000_0000, 1'b1, '{STS_OK,        32'h0000_0000, 7'd4}},
        '{ACT_DEQUEUE, 32'h0000_0000, 1'b1, '{STS_OK,        32'h7FFF_FFFF, 7'd3}},
        '{ACT_PEEK,    32'h5A5A_5A5A, 1'b1, '{STS_OK,        32'h0000_0000, 7'd3}},
        // back entry
        '{ACT_REMOVE,  32'h8000_0000, 1'b0, '{STS_OK,        32'h0000_0000, 7'd0}},
        '{ACT_DEQUEUE, 32'h0000_0000, 1'b0, '{STS_OK,        32'h0000_0000, 7'd0}},
        '{ACT_ENQUEUE, 32'h5555_5555, 1'b0, '{STS_OK,        32'h0000_0000, 7'd0}},
        '{ACT_ENQUEUE, 32'hAAAA_AAAA, 1'b0, '{STS_OK,        32'h0000_0000, 7'd0}},
        // front entry
        '{ACT_REMOVE,  32'hFFFF_FFFF, 1'b0, '{STS_OK,        32'h0000_0000, 7'd0}},
        '{ACT_PEEK,    32'h0000_0000, 1'b0, '{STS_OK,        32'h0000_0000, 7'd0}},
        '{ACT_DEQUEUE, 32'hFFFF_FFFF, 1'b0, '{STS_OK,        32'h0000_0000, 7'd0}},
        '{ACT_REMOVE,  32'hAAAA_AAAA, 1'b1, '{STS_OK,        32'h0000_0000, 7'd0}},
        '{ACT_REMOVE,  32'hAAAA_AAAA, 1'b1, '{STS_EMPTY,     32'h0000_0000, 7'd0}}
    };

    queue_with_remove_by_value_top #(
        .DEPTH    (DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit, several times the slowest legal run
    initial begin
        #10_000_000;
        $display("queue_with_remove_by_value_top_tb: FAIL");
        $finish;
    end

    // Apply one operation to the predicted queue and return the beat it should produce
    function automatic q_result_t queue_op_result(action_t act, logic [31:0] val);
        q_result_t res;
        int        hit;
        res = '{status: STS_OK, data: '0, occupancy: '0};
        case (act)
            ACT_ENQUEUE: begin
                if (held_q.size() >= DEPTH) res.status = STS_FULL;
                else held_q.push_back(val);
            end
            ACT_DEQUEUE: begin
                if (held_q.size() == 0) res.status = STS_EMPTY;
                else res.data = held_q.pop_front();
            end
            ACT_PEEK: begin
                if (held_q.size() == 0) res.status = STS_EMPTY;
                else res.data = held_q[0];
            end
            default: begin
                hit = -1;
                foreach (held_q[k]) begin
                    if (hit < 0 && held_q[k] == val) hit = k;
                end
                if (held_q.size() == 0) res.status = STS_EMPTY;
                else if (hit < 0) res.status = STS_NOT_FOUND;
                else held_q.delete(hit);
            end
        endcase
        res.occupancy = OCC_W'(held_q.size());
        return res;
    endfunction

    // Drive one input beat after a random gap; record what it should produce once accepted
    task automatic send_request(action_t act, logic [31:0] val, logic known, q_result_t want);
        int        gap;
        q_result_t res;
        gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
        res = queue_op_result(act, val);
        pending_results.push_back(known ? want : res);
    endtask

    // Values drawn from a few signed numbers near zero so that duplicates are common
    function automatic logic [31:0] pool_value();
        return 32'($signed($urandom_range(0, 7)) - 4);
    endfunction

    // Reset, directed table, random mixes, drain and verdict
    initial begin : stimulus
        mix_t        mix;
        int          rnd_left;
        int          phase;
        int          len;
        int          pick;
        action_t     act;
        logic [31:0] val;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_ENQUEUE;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIR; i++) begin
            send_request(dir_rows[i].act, dir_rows[i].value, dir_rows[i].known,
                         dir_rows[i].want);
        end

        // random part: first phase fills to the top, second drains, then random mixes
        rnd_left = N_RANDOM;
        phase    = 0;
        while (rnd_left > 0) begin
            mix     = (phase == 0) ? MIX_FILL : (phase == 1) ? MIX_DRAIN
                                              : mix_t'($urandom_range(0, 2));
            len     = (phase == 0) ? 120 : $urandom_range(40, 160);
            idle_on = (phase == 0) || ($urandom_range(0, 3) != 0);
            // hold off until the block has handed back everything owed
            if (phase == 3) begin
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
            end
            for (int n = 0; n < len && rnd_left > 0; n++) begin
                pick = $urandom_range(0, 99);
                case (mix)
                    MIX_FILL:  act = (pick < 85) ? ACT_ENQUEUE : (pick < 90) ? ACT_DEQUEUE
                                   : (pick < 94) ? ACT_PEEK : ACT_REMOVE;
                    MIX_DRAIN: act = (pick < 15) ? ACT_ENQUEUE : (pick < 50) ? ACT_DEQUEUE
                                   : (pick < 60) ? ACT_PEEK : ACT_REMOVE;
                    default:   act = (pick < 35) ? ACT_ENQUEUE : (pick < 60) ? ACT_DEQUEUE
                                   : (pick < 72) ? ACT_PEEK : ACT_REMOVE;
                endcase
                pick = $urandom_range(0, 99);
                val  = $urandom;
                if (act == ACT_ENQUEUE) begin
                    if (pick < 40) val = pool_value();
                    else if (pick < 50) begin
                        case ($urandom_range(0, 3))
                            0:       val = 32'h7FFF_FFFF;
                            1:       val = 32'h8000_0000;
                            2:       val = 32'h0000_0000;
                            default: val = 32'hFFFF_FFFF;
                        endcase
                    end
                end else if (act == ACT_REMOVE) begin
                    // mostly values that are held, so the search finds them anywhere
                    if (pick < 75 && held_q.size() != 0)
                        val = held_q[$urandom_range(0, held_q.size() - 1)];
                    else if (pick < 85)
                        val = pool_value();
                end
                send_request(act, val, 1'b0, '0);
                rnd_left--;
            end
            phase++;
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DEPTH + 20) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("queue_with_remove_by_value_top_tb: PASS");
        end else begin
            $display("queue_with_remove_by_value_top_tb: FAIL");
        end
        $finish;
    end

    // Result side: random stall before each beat, ready held through the handshake
    initial begin : result_sink
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Compare each accepted result beat with the oldest owed result
    always @(posedge aclk) begin : result_check
        q_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing owed: tuser %0d tdata %h", m_tuser, m_tdata);
                fail_cnt++;
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    fail_cnt++;
                end
                if (m_tdata[31:0] !== want.data) begin
                    $error("data: expected %0d, actual %0d",
                           $signed(want.data), $signed(m_tdata[31:0]));
                    fail_cnt++;
                end
                if (m_tdata[38:32] !== want.occupancy) begin
                    $error("occupancy: expected %0d, actual %0d",
                           want.occupancy, m_tdata[38:32]);
                    fail_cnt++;
                end
                if (m_tdata[39] !== 1'b0) begin
                    $error("tdata pad bit: expected 0, actual %b", m_tdata[39]);
                    fail_cnt++;
                end
            end
        end
    end

endmodule

// ----- filelist.f -----
sv/qrbv_pkg.sv
sv/qrbv_mem.sv
sv/queue_with_remove_by_value_top.sv
tb/queue_with_remove_by_value_top_tb.sv
